// File: rtl/bal_pkg.sv
package bal_pkg;

  localparam int unsigned CAPACITY_DEF = 8;
  localparam int unsigned STEPS_W      = 8;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_DELETE = 2'd1,
    K_SEARCH = 2'd2,
    K_ROTATE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_NOTFULL  = 3'd5
  } status_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

// File: rtl/bounded_array_list.sv
// Bounded ordered list of signed 32-bit words with room for CAPACITY entries.
// Requests arrive on the input channel (in_valid_i / in_ready_o) and each one
// gives exactly one result transaction on the output channel
// (out_valid_o / out_ready_i), carrying a status, the removed value, the found
// index and the entry count after the request.
// The block handles one request at a time and is not ready while it works.
// The entries live in a single RAM with one write and one registered read
// port, walked one entry per cycle. A request refused by its checks, and an
// append, pass from acceptance through the finishing state into the result
// register. An insert moves the entries from its position up by one, a
// delete moves those above its position down, and a search reads entries
// until a match or the count. A rotation moves only a base pointer; its step
// count is reduced modulo CAPACITY by a reciprocal multiplication in the remainder unit.
// Reset empties the list; the RAM is not cleared, since only entries below
// the count are ever read. A result waits in the output register while the
// receiver stalls; the next request can be taken meanwhile, but its own
// result is held back until the output register is free.
module bounded_array_list #(
  parameter int unsigned CAPACITY = bal_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic signed [31:0]            value_i,
  input  logic [2:0]                    position_i,
  input  logic [bal_pkg::STEPS_W-1:0]   rotate_steps_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic signed [31:0]            removed_value_o,
  output logic [2:0]                    found_index_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o
);
  import bal_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned BW = AW + 1;
  localparam int unsigned XW = (CW > 3) ? CW : 3;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_DEL  = 6'b000100,
    S_SRCH = 6'b001000,
    S_MOD  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(b) + SW'(l);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  base_q, base_d;
  logic [CW-1:0]  n_q, n_d;
  logic [CW-1:0]  rd_l_q, rd_l_d;
  logic [CW-1:0]  wl_q, wl_d;
  logic           fly_q, fly_d;
  logic           first_q, first_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic [31:0]    val_q, val_d;
  status_e        st_q, st_d;
  logic [31:0]    rem_q, rem_d;
  logic [2:0]     fidx_q, fidx_d;
  logic           out_valid_q, out_valid_d;
  status_e        out_st_q, out_st_d;
  logic [31:0]    out_rem_q, out_rem_d;
  logic [2:0]     out_fidx_q, out_fidx_d;
  logic [CW-1:0]  out_cnt_q, out_cnt_d;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [31:0]    ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [31:0]    ram_rdata;

  logic           mod_start;
  mod_stat_t      mod_st;
  logic [AW-1:0]  mod_rem;

  bal_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bal_mod #(
    .CAPACITY (CAPACITY)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .steps_i (rotate_steps_i),
    .stat_o  (mod_st),
    .rem_o   (mod_rem)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    base_d      = base_q;
    n_d         = n_q;
    rd_l_d      = rd_l_q;
    wl_d        = wl_q;
    fly_d       = fly_q;
    first_d     = first_q;
    pos_d       = pos_q;
    val_d       = val_q;
    st_d        = st_q;
    rem_d       = rem_q;
    fidx_d      = fidx_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_rem_d   = out_rem_q;
    out_fidx_d  = out_fidx_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = phys(base_q, wl_q);
    ram_wdata   = ram_rdata;
    ram_raddr   = phys(base_q, rd_l_q);
    mod_start   = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d   = value_i;
          rem_d   = '0;
          fidx_d  = '0;
          st_d    = ST_OK;
          fly_d   = 1'b0;
          state_d = S_FIN;
          unique case (kind_e'(kind_i))
            K_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                st_d = ST_FULL;
              end else if (XW'(position_i) > XW'(count_q)) begin
                st_d = ST_BADPOS;
              end else if (XW'(position_i) == XW'(count_q)) begin
                ram_we    = 1'b1;
                ram_waddr = phys(base_q, count_q);
                ram_wdata = value_i;
                count_d   = count_q + 1'b1;
              end else begin
                pos_d   = CW'(position_i);
                n_d     = count_q - CW'(position_i);
                rd_l_d  = count_q - 1'b1;
                state_d = S_INS;
              end
            end
            K_DELETE: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY;
              end else if (XW'(position_i) >= XW'(count_q)) begin
                st_d = ST_BADPOS;
              end else begin
                pos_d   = CW'(position_i);
                n_d     = count_q - CW'(position_i);
                rd_l_d  = CW'(position_i);
                first_d = 1'b1;
                state_d = S_DEL;
              end
            end
            K_SEARCH: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                n_d     = count_q;
                rd_l_d  = '0;
                state_d = S_SRCH;
              end
            end
            K_ROTATE: begin
              if (count_q != CW'(CAPACITY)) begin
                st_d = ST_NOTFULL;
              end else begin
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
            end
          endcase
        end
      end
      S_INS: begin
        if (fly_q) begin
          ram_we = 1'b1;
        end
        if (n_q != '0) begin
          fly_d  = 1'b1;
          wl_d   = rd_l_q + 1'b1;
          rd_l_d = rd_l_q - 1'b1;
          n_d    = n_q - 1'b1;
        end else begin
          fly_d = 1'b0;
          if (!fly_q) begin
            ram_we    = 1'b1;
            ram_waddr = phys(base_q, pos_q);
            ram_wdata = val_q;
            count_d   = count_q + 1'b1;
            state_d   = S_FIN;
          end
        end
      end
      S_DEL: begin
        if (fly_q) begin
          if (first_q) begin
            rem_d   = ram_rdata;
            first_d = 1'b0;
          end else begin
            ram_we = 1'b1;
          end
        end
        if (n_q != '0) begin
          fly_d  = 1'b1;
          wl_d   = rd_l_q - 1'b1;
          rd_l_d = rd_l_q + 1'b1;
          n_d    = n_q - 1'b1;
        end else begin
          fly_d = 1'b0;
          if (!fly_q) begin
            count_d = count_q - 1'b1;
            state_d = S_FIN;
          end
        end
      end
      S_SRCH: begin
        if (fly_q && (ram_rdata == val_q)) begin
          fidx_d  = 3'(wl_q);
          fly_d   = 1'b0;
          state_d = S_FIN;
        end else if (n_q != '0) begin
          fly_d  = 1'b1;
          wl_d   = rd_l_q;
          rd_l_d = rd_l_q + 1'b1;
          n_d    = n_q - 1'b1;
        end else begin
          fly_d = 1'b0;
          if (!fly_q) begin
            st_d    = ST_NOTFOUND;
            state_d = S_FIN;
          end
        end
      end
      S_MOD: begin
        if (mod_st.done) begin
          base_d  = AW'(BW'(base_q) + BW'(CAPACITY) - BW'(mod_rem));
          if (base_q >= mod_rem) begin
            base_d = base_q - mod_rem;
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_rem_d   = rem_q;
          out_fidx_d  = fidx_q;
          out_cnt_d   = count_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      base_q      <= '0;
      n_q         <= '0;
      fly_q       <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      base_q      <= base_d;
      n_q         <= n_d;
      fly_q       <= fly_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_l_q     <= rd_l_d;
    wl_q       <= wl_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    st_q       <= st_d;
    rem_q      <= rem_d;
    fidx_q     <= fidx_d;
    out_st_q   <= out_st_d;
    out_rem_q  <= out_rem_d;
    out_fidx_q <= out_fidx_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign removed_value_o = out_rem_q;
  assign found_index_o   = out_fidx_q;
  assign entry_count_o   = out_cnt_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(count_q) <= SW'(CAPACITY)))
    else $error("Entry count exceeds the capacity.");

  a_base_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (BW'(base_q) < BW'(CAPACITY)))
    else $error("Base pointer is outside the list.");

  a_search_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> !ram_we)
    else $error("RAM written during a search.");

  a_mod_in_rotate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_st.busy || mod_st.done) |-> (state_q == S_MOD))
    else $error("Remainder unit active outside a rotation.");

  a_fin_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && (!out_valid_q || out_ready_i)) |=>
      (out_valid_q && (state_q == S_IDLE)))
    else $error("Finished result was not loaded into the output register.");

endmodule

// File: rtl/bal_ram.sv
module bal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bal_mod.sv
module bal_mod #(
  parameter int unsigned CAPACITY = bal_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bal_pkg::STEPS_W-1:0] steps_i,
  output bal_pkg::mod_stat_t          stat_o,
  output logic [$clog2(CAPACITY)-1:0] rem_o
);
  import bal_pkg::*;

  localparam int unsigned        AW    = $clog2(CAPACITY);
  localparam int unsigned        RSH   = 2 * STEPS_W;
  localparam int unsigned        PW    = STEPS_W + RSH;
  localparam int unsigned        RECIP = ((1 << RSH) + CAPACITY - 1) / CAPACITY;
  localparam logic [STEPS_W-1:0] CAP_S = STEPS_W'(CAPACITY);

  logic [STEPS_W-1:0] steps_q, steps_d;
  logic [STEPS_W-1:0] quot_q, quot_d;
  logic [STEPS_W-1:0] rem_q, rem_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [PW-1:0]      prod;

  // The scaled reciprocal is exact for every step count of STEPS_W bits.
  assign prod = PW'(steps_i) * PW'(RECIP);

  always_comb begin
    steps_d = steps_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    busy_d  = 1'b0;
    done_d  = 1'b0;
    if (start_i) begin
      steps_d = steps_i;
      quot_d  = prod[RSH +: STEPS_W];
      busy_d  = 1'b1;
    end else if (busy_q) begin
      rem_d  = steps_q - quot_q * CAP_S;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d;
    quot_q  <= quot_d;
    rem_q   <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q[AW-1:0];

endmodule
